### rtl/port_byte_counter_rate_history_top_defines.svh
// Assertion macros shared by the port byte counter rate history RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef PORT_BYTE_COUNTER_RATE_HISTORY_TOP_DEFINES_SVH
`define PORT_BYTE_COUNTER_RATE_HISTORY_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PBC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pbc_pkg.sv
// Shared types and constants for the port byte counter rate history block.
// No dependencies; used by pbc_ctrl, pbc_datapath and the top level.
package pbc_pkg;

  localparam int PORT_W   = 3;
  localparam int COUNT_W  = 64;
  localparam int US_W     = 32;
  localparam int LAG_W    = 10;
  localparam int ROWS_W   = 11;
  localparam int RATE_W   = 63;
  localparam int STATUS_W = 2;

  localparam logic [ROWS_W-1:0] ROWS_RESET = 11'd60;

  // rate = floor(delta * 8000000 / interval) >> 10, saturated at 2^63-1
  localparam int HALF_W    = 32;
  localparam int SCALE_W   = 23;
  localparam logic [SCALE_W-1:0] RATE_SCALE = 23'd8000000;
  localparam int MRES_W    = HALF_W + SCALE_W;
  localparam int PROD_W    = COUNT_W + SCALE_W;
  localparam int DROP_BITS = 10;
  localparam int TOP_LSB   = RATE_W + DROP_BITS;
  localparam int DIV_STEPS = RATE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_LAG   = 2'd1,
    ST_ZERO_US   = 2'd2,
    ST_NO_SAMPLE = 2'd3
  } status_t;

  typedef struct packed {
    logic [US_W-1:0]    interval;
    logic [COUNT_W-1:0] tx;
    logic [COUNT_W-1:0] rx;
  } sample_t;

  typedef struct packed {
    logic capture;
    logic write_ring;
    logic check;
    logic rd_new;
    logic rd_old;
    logic delta;
    logic mul_lo;
    logic mul_hi;
    logic prep;
    logic div_step;
    logic load_out;
  } pbc_cmd_t;

  typedef struct packed {
    logic check_fail;
    logic zero_us;
  } pbc_sts_t;

endpackage

### rtl/pbc_ctrl.sv
// Sequencing state machine for the port byte counter rate history block.
// Depends on pbc_pkg and the assertion macro header.
`include "port_byte_counter_rate_history_top_defines.svh"

module pbc_ctrl import pbc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     func,
  output logic     out_valid,
  input  logic     out_ready,
  output pbc_cmd_t cmd,
  input  pbc_sts_t sts
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_WRITE  = 11'b00000000010,
    S_CHECK  = 11'b00000000100,
    S_RD_NEW = 11'b00000001000,
    S_RD_OLD = 11'b00000010000,
    S_DELTA  = 11'b00000100000,
    S_MUL_LO = 11'b00001000000,
    S_MUL_HI = 11'b00010000000,
    S_PREP   = 11'b00100000000,
    S_DIV    = 11'b01000000000,
    S_FINISH = 11'b10000000000
  } state_t;

  state_t               state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;
  logic                 out_valid_next;
  logic                 out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = func ? S_CHECK : S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_ring = 1'b1;
        state_next     = S_IDLE;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.check_fail ? S_FINISH : S_RD_NEW;
      end
      S_RD_NEW: begin
        cmd.rd_new = 1'b1;
        state_next = S_RD_OLD;
      end
      S_RD_OLD: begin
        cmd.rd_old = 1'b1;
        state_next = S_DELTA;
      end
      S_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = sts.zero_us ? S_FINISH : S_MUL_LO;
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_next = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_next = S_PREP;
      end
      S_PREP: begin
        cmd.prep     = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold the result until the output register frees up
        cmd.load_out = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      div_cnt   <= div_cnt_next;
      out_valid <= out_valid_next;
    end
  end

  `PBC_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")
  `PBC_ASSERT_NXT(a_load_sets_valid, clk, rst, cmd.load_out, out_valid, "result not presented")
  `PBC_ASSERT_NXT(a_div_ends, clk, rst, state == S_DIV && div_cnt == DIV_LAST, state == S_FINISH, "divide overran")

endmodule

### rtl/pbc_datapath.sv
// Datapath: per-port ring memory, slot tables, rate multiply and divide lanes.
// Depends on pbc_pkg and the assertion macro header.
`include "port_byte_counter_rate_history_top_defines.svh"

module pbc_datapath import pbc_pkg::*; #(
  parameter int PORTS         = 8,
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  pbc_cmd_t            cmd,
  output pbc_sts_t            sts,
  input  logic [PORT_W-1:0]   port,
  input  logic [COUNT_W-1:0]  rx_count,
  input  logic [COUNT_W-1:0]  tx_count,
  input  logic [US_W-1:0]     interval_usec,
  input  logic [LAG_W-1:0]    lag,
  input  logic [ROWS_W-1:0]   rows_shown,
  output logic [RATE_W-1:0]   rx_rate_kbit,
  output logic [RATE_W-1:0]   tx_rate_kbit,
  output logic [STATUS_W-1:0] status
);

  // only ports reachable by the port field get storage
  localparam int NPORT      = (PORTS < (1 << PORT_W)) ? PORTS : (1 << PORT_W);
  localparam int PIDX_W     = (NPORT > 1) ? $clog2(NPORT) : 1;
  localparam int HIST_W     = $clog2(HISTORY_DEPTH);
  localparam int CNT_W      = HIST_W + 1;
  localparam int AGE_W      = (CNT_W > LAG_W) ? CNT_W : LAG_W;
  localparam int RING_DEPTH = NPORT * HISTORY_DEPTH;
  localparam int ADDR_W     = $clog2(RING_DEPTH);

  // captured item
  logic [PORT_W-1:0]  port_r;
  logic [COUNT_W-1:0] rx_in_r, tx_in_r;
  logic [US_W-1:0]    us_in_r;
  logic [LAG_W-1:0]   lag_r;

  logic [HIST_W-1:0] ws_tbl  [NPORT];
  logic [CNT_W-1:0]  cnt_tbl [NPORT];

  sample_t ring [RING_DEPTH];
  sample_t rd_data, new_r;

  logic [PIDX_W-1:0] pidx;
  logic              known;
  logic [HIST_W-1:0] ws_cur;
  logic [CNT_W-1:0]  cnt_cur;
  logic [AGE_W-1:0]  lag_age;
  logic              lag_bad, no_sample;
  logic [HIST_W-1:0] slot_new_r, slot_old_r, slot_sel;
  logic [ADDR_W-1:0] port_off, addr;
  status_t           status_r;

  // rx is lane 0, tx is lane 1
  logic [COUNT_W-1:0]  dlt   [2];
  logic [HALF_W-1:0]   mop   [2];
  logic [MRES_W-1:0]   mres  [2];
  logic [MRES_W-1:0]   plo   [2];
  logic [PROD_W-1:0]   prod  [2];
  logic [US_W-1:0]     rem   [2];
  logic [US_W:0]       trial [2];
  logic [US_W:0]       rsub  [2];
  logic                ge    [2];
  logic [RATE_W-1:0]   quot  [2];
  logic                sat   [2];
  logic [COUNT_W-1:0]  newv  [2];
  logic [COUNT_W-1:0]  oldv  [2];
  logic [US_W-1:0]     us_r;

  function automatic logic [HIST_W-1:0] slot_at(input logic [HIST_W-1:0] ws,
                                                input logic [CNT_W-1:0]  n,
                                                input logic [AGE_W-1:0]  age);
    logic [AGE_W-1:0] last;
    logic [AGE_W-1:0] age_c;
    logic [HIST_W:0]  base;
    last  = AGE_W'(n) - AGE_W'(1);
    // ages past the first sample read the first sample
    age_c = (age > last) ? last : age;
    base  = {1'b0, ws} + (HIST_W+1)'(HISTORY_DEPTH - 1) - (HIST_W+1)'(age_c);
    if (base >= (HIST_W+1)'(HISTORY_DEPTH)) begin
      base = base - (HIST_W+1)'(HISTORY_DEPTH);
    end
    return base[HIST_W-1:0];
  endfunction

  assign pidx    = port_r[PIDX_W-1:0];
  assign known   = (int'(port_r) < PORTS);
  assign ws_cur  = ws_tbl[pidx];
  assign cnt_cur = cnt_tbl[pidx];
  assign lag_age = AGE_W'(lag_r);

  assign lag_bad = (lag_r == '0) || (ROWS_W'(lag_r) >= rows_shown)
                   || (lag_age >= AGE_W'(HISTORY_DEPTH));
  assign no_sample = !known || (cnt_cur == '0);

  assign sts.check_fail = lag_bad || no_sample;
  assign sts.zero_us    = (new_r.interval == '0);

  assign slot_sel = cmd.write_ring ? ws_cur : (cmd.rd_new ? slot_new_r : slot_old_r);
  assign port_off = ADDR_W'(int'(pidx) * HISTORY_DEPTH);
  assign addr     = port_off + ADDR_W'(slot_sel);

  assign newv[0] = new_r.rx;
  assign newv[1] = new_r.tx;
  assign oldv[0] = rd_data.rx;
  assign oldv[1] = rd_data.tx;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mop[l]   = cmd.mul_hi ? dlt[l][COUNT_W-1:HALF_W] : dlt[l][HALF_W-1:0];
      mres[l]  = mop[l] * RATE_SCALE;
      trial[l] = {rem[l], prod[l][TOP_LSB-1]};
      rsub[l]  = trial[l] - {1'b0, us_r};
      ge[l]    = (trial[l] >= {1'b0, us_r});
    end
  end

  // ring memory: one address per cycle, registered read
  always_ff @(posedge clk) begin
    if (cmd.write_ring && known) begin
      ring[addr] <= '{interval: us_in_r, tx: tx_in_r, rx: rx_in_r};
    end
    rd_data <= ring[addr];
  end

  // per-port slot pointer and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NPORT; p++) begin
        ws_tbl[p]  <= '0;
        cnt_tbl[p] <= '0;
      end
    end else if (cmd.write_ring && known) begin
      ws_tbl[pidx] <= (ws_cur == HIST_W'(HISTORY_DEPTH - 1)) ? '0 : ws_cur + 1'b1;
      if (cnt_cur != CNT_W'(HISTORY_DEPTH)) begin
        cnt_tbl[pidx] <= cnt_cur + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      port_r  <= port;
      rx_in_r <= rx_count;
      tx_in_r <= tx_count;
      us_in_r <= interval_usec;
      lag_r   <= lag;
    end
    if (cmd.check) begin
      status_r   <= lag_bad ? ST_BAD_LAG : (no_sample ? ST_NO_SAMPLE : ST_OK);
      slot_new_r <= slot_at(ws_cur, cnt_cur, lag_age - AGE_W'(1));
      slot_old_r <= slot_at(ws_cur, cnt_cur, lag_age);
    end
    if (cmd.rd_old) begin
      new_r <= rd_data;
    end
    if (cmd.delta) begin
      us_r <= new_r.interval;
      if (sts.zero_us) begin
        status_r <= ST_ZERO_US;
      end
    end
    for (int l = 0; l < 2; l++) begin
      if (cmd.delta) begin
        dlt[l] <= newv[l] - oldv[l];
      end
      if (cmd.mul_lo) begin
        plo[l] <= mres[l];
      end
      if (cmd.mul_hi) begin
        prod[l] <= {mres[l], {HALF_W{1'b0}}} + PROD_W'(plo[l]);
      end
      if (cmd.prep) begin
        // quotient bits above the kept range force saturation
        sat[l] <= (US_W'(prod[l][PROD_W-1:TOP_LSB]) >= us_r);
        rem[l] <= US_W'(prod[l][PROD_W-1:TOP_LSB]);
      end
      if (cmd.div_step) begin
        rem[l]  <= ge[l] ? rsub[l][US_W-1:0] : trial[l][US_W-1:0];
        quot[l] <= {quot[l][RATE_W-2:0], ge[l]};
        prod[l] <= prod[l] << 1;
      end
    end
    if (cmd.load_out) begin
      rx_rate_kbit <= (status_r != ST_OK) ? '0 : (sat[0] ? '1 : quot[0]);
      tx_rate_kbit <= (status_r != ST_OK) ? '0 : (sat[1] ? '1 : quot[1]);
      status       <= status_r;
    end
  end

  `PBC_ASSERT_NXT(a_store_counts, clk, rst, cmd.write_ring && known, cnt_tbl[pidx] != '0, "fill count stuck at zero")
  `PBC_ASSERT_IMP(a_rem_bound, clk, rst, cmd.div_step && !sat[0], rem[0] < us_r, "rx remainder out of range")
  `PBC_ASSERT_NXT(a_fail_zero_rate, clk, rst, cmd.load_out && status_r != ST_OK, rx_rate_kbit == '0 && tx_rate_kbit == '0, "rate on failed read")

endmodule

### rtl/port_byte_counter_rate_history_top.sv
// Top level of the port byte counter rate history block.
// Depends on pbc_pkg, pbc_ctrl and pbc_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready): one item per request. func 0 stores a
//   sample (rx_count, tx_count, interval_usec) into the next ring slot of
//   port; func 1 reads rx/tx rates in kbit/s for the sample pair lag-1/lag.
//   Output channel (out_valid/out_ready): one item per read, none per store.
//   Config channel (cfg_valid/cfg_ready/cfg_data): writes rows_shown; always
//   ready, write it only while the block is idle.
// Sequence:
//   A store holds in_ready low while it writes the ring. A full read steps
//   through check, new and old ring reads, delta, low and high multiply,
//   divide prep and the 63-step restoring divider, then loads the output
//   register once free and only then takes a new item. A rejected lag or
//   unsampled port goes to that load after check, a zero interval after delta.
// Reset: clears the slot pointers, fill counts and output valid, and sets
//   rows_shown to 60. Ring contents are only read once written.
// Stall: a pending result sits in the output register; the next item is
//   still accepted, and a later read holds in its last step until the
//   output register is taken.

module port_byte_counter_rate_history_top import pbc_pkg::*; #(
  parameter int PORTS         = 8,
  parameter int HISTORY_DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                func,
  input  logic [PORT_W-1:0]   port,
  input  logic [COUNT_W-1:0]  rx_count,
  input  logic [COUNT_W-1:0]  tx_count,
  input  logic [US_W-1:0]     interval_usec,
  input  logic [LAG_W-1:0]    lag,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [RATE_W-1:0]   rx_rate_kbit,
  output logic [RATE_W-1:0]   tx_rate_kbit,
  output logic [STATUS_W-1:0] status,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ROWS_W-1:0]   cfg_data
);

  pbc_cmd_t          cmd;
  pbc_sts_t          sts;
  logic [ROWS_W-1:0] rows_shown;

  // config register takes a write every cycle it is offered
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_shown <= ROWS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rows_shown <= cfg_data;
    end
  end

  // sequencer: owns the handshakes and steps the datapath
  pbc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // ring memory, slot tables, multiply and divide lanes, output register
  pbc_datapath #(
    .PORTS         (PORTS),
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .port          (port),
    .rx_count      (rx_count),
    .tx_count      (tx_count),
    .interval_usec (interval_usec),
    .lag           (lag),
    .rows_shown    (rows_shown),
    .rx_rate_kbit  (rx_rate_kbit),
    .tx_rate_kbit  (tx_rate_kbit),
    .status        (status)
  );

endmodule

### dv/port_byte_counter_rate_history_top_test.sv
// Self-checking testbench for port_byte_counter_rate_history_top: per-port
// sample history with rx/tx rate readout, checked item by item against an
// in-bench predictor. Depends on pbc_pkg and the top level RTL only.
module port_byte_counter_rate_history_top_test;
  import pbc_pkg::*;

  localparam int PORT_COUNT = 8;
  localparam int RING_DEPTH = 1024;
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;
  // bytes per usec -> bits per sec, then bit/s -> kbit/s by a 10-bit shift
  localparam logic [22:0] BIT_RATE_SCALE = 23'd8000000;
  localparam int PRODUCT_W  = COUNT_W + 23;
  localparam int KBIT_SHIFT = 10;
  localparam logic [RATE_W-1:0] RATE_CEILING = '1;
  localparam int RANDOM_PHASE_ITEMS = 25;
  // Leave room for a full read and a stalled output.
  localparam int SETTLE_CYCLES = 100;
  localparam int CYCLE_LIMIT   = 2_000_000;

  typedef struct {
    logic [RATE_W-1:0] rx;
    logic [RATE_W-1:0] tx;
    status_t           status;
  } rate_readout_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  // Block ports; every input starts at a known value
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                func = FUNC_STORE;
  logic [PORT_W-1:0]   port = '0;
  logic [COUNT_W-1:0]  rx_count = '0;
  logic [COUNT_W-1:0]  tx_count = '0;
  logic [US_W-1:0]     interval_usec = '0;
  logic [LAG_W-1:0]    lag = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [RATE_W-1:0]   rx_rate_kbit;
  logic [RATE_W-1:0]   tx_rate_kbit;
  logic [STATUS_W-1:0] status;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ROWS_W-1:0]   cfg_data = '0;

  port_byte_counter_rate_history_top #(
    .PORTS         (PORT_COUNT),
    .HISTORY_DEPTH (RING_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .port          (port),
    .rx_count      (rx_count),
    .tx_count      (tx_count),
    .interval_usec (interval_usec),
    .lag           (lag),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .rx_rate_kbit  (rx_rate_kbit),
    .tx_rate_kbit  (tx_rate_kbit),
    .status        (status),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // Predictor state: the sample history of each port, its write pointer and
  // fill count, and the current row limit.
  logic [COUNT_W-1:0] hist_rx [PORT_COUNT][RING_DEPTH];
  logic [COUNT_W-1:0] hist_tx [PORT_COUNT][RING_DEPTH];
  logic [US_W-1:0]    hist_us [PORT_COUNT][RING_DEPTH];
  int unsigned        next_slot [PORT_COUNT];
  int unsigned        fill_count [PORT_COUNT];
  logic [ROWS_W-1:0]  rows_limit;

  // Rates still owed by the block, oldest first
  rate_readout_t rate_readout_q[$];

  // Counters of the sample generator, one pair per port
  logic [COUNT_W-1:0] gen_rx [PORT_COUNT];
  logic [COUNT_W-1:0] gen_tx [PORT_COUNT];

  bit calm = 1'b0;  // set: no gaps on input, no stalls on output
  int mismatch_count = 0;
  int cycle_count = 0;
  int unsigned stall_left = 0;

  // Exact product, then floor division, then drop to kbit and saturate.
  function automatic logic [RATE_W-1:0] kbit_rate(logic [COUNT_W-1:0] delta,
                                                  logic [US_W-1:0] us);
    logic [PRODUCT_W-1:0] bits_scaled;
    logic [PRODUCT_W-1:0] kbit;
    bits_scaled = PRODUCT_W'(delta) * PRODUCT_W'(BIT_RATE_SCALE);
    kbit = (bits_scaled / PRODUCT_W'(us)) >> KBIT_SHIFT;
    if (kbit[PRODUCT_W-1:RATE_W] != '0) return RATE_CEILING;
    return kbit[RATE_W-1:0];
  endfunction

  // Ages past the oldest stored sample read as the first sample, as if the
  // ring had been prefilled with it.
  function automatic int unsigned slot_for_age(int unsigned p, int unsigned age);
    int unsigned clamped;
    clamped = (age > fill_count[p] - 1) ? fill_count[p] - 1 : age;
    return (next_slot[p] + RING_DEPTH - 1 - clamped) % RING_DEPTH;
  endfunction

  // Advance the predictor by one accepted item; queue the result of a read.
  task automatic track_accepted_item(logic f, logic [PORT_W-1:0] p,
                                     logic [COUNT_W-1:0] rx, logic [COUNT_W-1:0] tx,
                                     logic [US_W-1:0] us, logic [LAG_W-1:0] k);
    rate_readout_t r;
    int unsigned newer;
    int unsigned older;
    if (f == FUNC_STORE) begin
      hist_rx[p][next_slot[p]] = rx;
      hist_tx[p][next_slot[p]] = tx;
      hist_us[p][next_slot[p]] = us;
      next_slot[p] = (next_slot[p] + 1) % RING_DEPTH;
      if (fill_count[p] < RING_DEPTH) fill_count[p]++;
    end else begin
      r.rx = '0;
      r.tx = '0;
      // lag check wins over everything, even an unsampled port
      if (k == '0 || {1'b0, k} >= rows_limit) begin
        r.status = ST_BAD_LAG;
      end else if (fill_count[p] == 0) begin
        r.status = ST_NO_SAMPLE;
      end else begin
        newer = slot_for_age(p, k - 1);
        older = slot_for_age(p, k);
        if (hist_us[p][newer] == '0) begin
          r.status = ST_ZERO_US;
        end else begin
          r.status = ST_OK;
          r.rx = kbit_rate(hist_rx[p][newer] - hist_rx[p][older], hist_us[p][newer]);
          r.tx = kbit_rate(hist_tx[p][newer] - hist_tx[p][older], hist_us[p][newer]);
        end
      end
      rate_readout_q.push_back(r);
    end
  endtask

  // Idle length: mostly none or short, a few long; none while calm.
  function automatic int pick_idle();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Present one item at the falling edge, hold it until accepted.
  task automatic send_item(logic f, logic [PORT_W-1:0] p,
                           logic [COUNT_W-1:0] rx, logic [COUNT_W-1:0] tx,
                           logic [US_W-1:0] us, logic [LAG_W-1:0] k);
    int gap;
    gap = pick_idle();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    func          <= f;
    port          <= p;
    rx_count      <= rx;
    tx_count      <= tx;
    interval_usec <= us;
    lag           <= k;
    do @(posedge clk); while (!in_ready);
    track_accepted_item(f, p, rx, tx, us, k);
  endtask

  // Unused fields carry random values; the block must ignore them.
  task automatic store_sample(logic [PORT_W-1:0] p, logic [COUNT_W-1:0] rx,
                              logic [COUNT_W-1:0] tx, logic [US_W-1:0] us);
    send_item(FUNC_STORE, p, rx, tx, us, LAG_W'($urandom));
  endtask

  task automatic read_rates(logic [PORT_W-1:0] p, logic [LAG_W-1:0] k);
    send_item(FUNC_READ, p, {$urandom, $urandom}, {$urandom, $urandom}, $urandom, k);
  endtask

  // Store the next sample of a port: mostly plausible once-a-second traffic,
  // the rest counter wraps, small deltas, zero and one-usec intervals, counter jumps.
  task automatic store_next_sample(int p);
    logic [COUNT_W-1:0] drx;
    logic [COUNT_W-1:0] dtx;
    logic [US_W-1:0]    us;
    int                 roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      drx = COUNT_W'($urandom_range(0, 200_000_000));
      dtx = COUNT_W'($urandom);
      us  = $urandom_range(900_000, 1_100_000);
    end else if (roll < 72) begin
      drx = {$urandom, $urandom};
      dtx = {$urandom, $urandom};
      us  = $urandom;
    end else if (roll < 80) begin
      drx = '0;
      dtx = COUNT_W'($urandom_range(0, 1000));
      us  = $urandom_range(1, 1000);
    end else if (roll < 86) begin
      drx = COUNT_W'($urandom);
      dtx = COUNT_W'($urandom);
      us  = '0;
    end else if (roll < 92) begin
      drx = {$urandom, $urandom} >> $urandom_range(0, 63);
      dtx = {$urandom, $urandom} >> $urandom_range(0, 63);
      us  = US_W'(1);
    end else begin
      gen_rx[p] = {$urandom, $urandom};
      gen_tx[p] = {$urandom, $urandom};
      drx = '0;
      dtx = '0;
      us  = $urandom;
    end
    gen_rx[p] += drx;
    gen_tx[p] += dtx;
    store_sample(PORT_W'(p), gen_rx[p], gen_tx[p], us);
  endtask

  // Read at a lag: mostly recent pairs, some anywhere below the limit, some
  // across the whole field so the limit gets hit.
  task automatic read_random_lag(int p);
    int hi_lag;
    int near_lag;
    int roll;
    logic [LAG_W-1:0] k;
    hi_lag   = (rows_limit > 1) ? int'(rows_limit) - 1 : 1;
    near_lag = (hi_lag < 12) ? hi_lag : 12;
    roll = $urandom_range(0, 99);
    if (roll < 50) k = LAG_W'($urandom_range(1, near_lag));
    else if (roll < 80) k = LAG_W'($urandom_range(1, hi_lag));
    else k = LAG_W'($urandom_range(0, (1 << LAG_W) - 1));
    read_rates(PORT_W'(p), k);
  endtask

  // Drop valid, wait for every owed result, then let any store finish.
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rate_readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rows_shown(logic [ROWS_W-1:0] rows);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= rows;
    do @(posedge clk); while (!cfg_ready);
    rows_limit = rows;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset row limit: rejected lags, unsampled ports, prefill pairs, zero and
  // maximal intervals, counter wrap and saturation.
  task automatic test_directed_cases();
    read_rates(0, 0);
    read_rates(0, 1);
    read_rates(7, 60);
    store_sample(0, 64'd1000, 64'd500, 32'd1_000_000);
    read_rates(0, 1);
    read_rates(0, 59);
    store_sample(0, 64'd125_001_000, 64'd500, 32'd1_000_000);
    read_rates(0, 1);
    read_rates(0, 2);
    store_sample(7, 64'hFFFF_FFFF_FFFF_FF00, '1, 32'd0);
    read_rates(7, 1);
    store_sample(7, 64'h0000_0000_0000_0100, '0, '1);
    read_rates(7, 1);
    store_sample(7, 64'h8000_0000_0000_0100, '1, 32'd1);
    read_rates(7, 1);
    read_rates(7, 2);
    read_rates(7, 3);
    read_rates(7, 59);
  endtask

  // Row limit at both extremes and just above the smallest.
  task automatic test_row_limits();
    settle_block();
    write_rows_shown(11'd1024);
    store_sample(2, 64'd0, 64'd0, 32'd1_000_000);
    store_sample(2, 64'd3_000_000, 64'd1, 32'd999_999);
    read_rates(2, 1023);
    read_rates(2, 1);
    settle_block();
    write_rows_shown(11'd1);
    read_rates(2, 1);
    settle_block();
    write_rows_shown(11'd2);
    read_rates(2, 1);
    read_rates(2, 2);
  endtask

  // Fill one port past the ring depth, then read around the wrap point and
  // at the deepest lags.
  task automatic test_ring_wrap();
    settle_block();
    write_rows_shown(11'd1024);
    calm = 1'b1;
    repeat (RING_DEPTH + 76) store_next_sample(4);
    calm = 1'b0;
    read_rates(4, 1);
    read_rates(4, 2);
    read_rates(4, 75);
    read_rates(4, 76);
    read_rates(4, 77);
    read_rates(4, 1022);
    read_rates(4, 1023);
    repeat (10) read_rates(4, LAG_W'($urandom_range(1, RING_DEPTH - 1)));
  endtask

  // Mixed stores and reads over a few row limits; ports 0 and 1 get most
  // traffic so their histories grow longest. Quiet stretches come and go.
  task automatic test_random_traffic();
    int p;
    for (int phase = 0; phase < 4; phase++) begin
      settle_block();
      case (phase)
        0: write_rows_shown(11'd1024);
        1: write_rows_shown(ROWS_W'($urandom_range(1, 1024)));
        2: write_rows_shown(ROWS_W'($urandom_range(2, 64)));
        default: write_rows_shown(ROWS_RESET);
      endcase
      for (int i = 0; i < RANDOM_PHASE_ITEMS; i++) begin
        if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
        p = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(0, 7);
        if ($urandom_range(0, 99) < 55) store_next_sample(p);
        else read_random_lag(p);
      end
      calm = 1'b0;
    end
  endtask

  // Output side: stall the result channel at random, hold each stall out.
  always @(negedge clk) begin
    int idle;
    idle = pick_idle();
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle > 0) begin
      out_ready <= 1'b0;
      stall_left <= idle - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest owed readout.
  always @(posedge clk) begin
    rate_readout_t owed;
    if (!rst && out_valid && out_ready) begin
      if (rate_readout_q.size() == 0) begin
        $display("%0t: result with no read pending: rx %0d tx %0d status %0d",
                 $time, rx_rate_kbit, tx_rate_kbit, status);
        mismatch_count++;
      end else begin
        owed = rate_readout_q.pop_front();
        if (rx_rate_kbit !== owed.rx) begin
          $display("%0t: rx_rate_kbit expected %0d actual %0d",
                   $time, owed.rx, rx_rate_kbit);
          mismatch_count++;
        end
        if (tx_rate_kbit !== owed.tx) begin
          $display("%0t: tx_rate_kbit expected %0d actual %0d",
                   $time, owed.tx, tx_rate_kbit);
          mismatch_count++;
        end
        if (status !== owed.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, owed.status, status);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("port_byte_counter_rate_history_top: mismatch");
      $finish;
    end
  end

  initial begin
    rows_limit = ROWS_RESET;
    for (int p = 0; p < PORT_COUNT; p++) begin
      next_slot[p]  = 0;
      fill_count[p] = 0;
      gen_rx[p]     = '0;
      gen_tx[p]     = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_row_limits();
    test_ring_wrap();
    test_random_traffic();
    settle_block();

    if (mismatch_count == 0)
      $display("port_byte_counter_rate_history_top: match");
    else
      $display("port_byte_counter_rate_history_top: mismatch");
    $finish;
  end

endmodule
